FILE: rtl/acs_pkg.sv
// Package for the accumulator CPU step unit: sizes, opcode limit, status
// codes, controller states and the command struct. No dependencies.
`default_nettype none
package acs_pkg;

	localparam int PROG_WORDS = 16384;
	localparam int DATA_WORDS = 65536;
	localparam int PROG_AW = $clog2(PROG_WORDS);
	localparam int DATA_AW = $clog2(DATA_WORDS);
	localparam logic [7:0] OP_LAST = 8'd79;
	localparam logic [6:0] SCR_MAX_X = 7'd99;
	localparam logic [8:0] SCR_MAX_Y = 9'd74;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_BADOP = 2'd2;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_PIXEL = 2'd1;
	localparam logic [1:0] EV_FLIP = 2'd2;

	localparam logic [0:0] CFG_IO_LOW_DIR = 1'b0;
	localparam logic [0:0] CFG_IO_HIGH_DIR = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_DECODE,
		S_OPER,
		S_EXEC,
		S_OUT
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_word;  // write the input word into program memory
		logic fetch;      // read program memory at the PC
		logic decode;     // latch the fetched instruction word
		logic oper_rd;    // issue operand reads for the fetched word
		logic exec;       // commit the instruction
		logic halt_out;   // report halted, change nothing
		logic load_out;   // report load done
		logic capture;    // capture the input item fields
	} ctl_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/acs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module acs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/acs_ctrl.sv
// Controller state machine for the CPU step unit.
// Depends on acs_pkg.
`default_nettype none
module acs_ctrl import acs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic in_kind,
	input  wire logic halted,
	output logic      out_valid,
	input  wire logic out_stall,
	output ctl_cmd_t  cmd
);
	ctl_state_t state_q, state_d;
	logic kind_q;

	wire logic take = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) state_d = S_FETCH;
			end
			S_FETCH: begin
				if (!kind_q || halted) state_d = S_OUT;
				else state_d = S_DECODE;
			end
			S_DECODE: state_d = S_OPER;
			S_OPER: state_d = S_EXEC;
			S_EXEC: state_d = S_OUT;
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = (state_q != S_IDLE);
		out_valid = (state_q == S_OUT);
		cmd.capture = take;
		unique case (state_q)
			S_FETCH: begin
				cmd.load_word = !kind_q;
				cmd.load_out = !kind_q;
				cmd.halt_out = kind_q && halted;
				cmd.fetch = kind_q && !halted;
			end
			S_DECODE: cmd.decode = 1'b1;
			S_OPER: cmd.oper_rd = 1'b1;
			S_EXEC: cmd.exec = 1'b1;
			default: ;
		endcase
	end

	// hold state and item kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) kind_q <= in_kind;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/acs_datapath.sv
// Datapath of the CPU step unit: registers, flags, program and data memory,
// operand selection and result registers. Depends on acs_pkg and acs_ram.
`default_nettype none
module acs_datapath import acs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  ctl_cmd_t         cmd,
	input  wire logic        cfg_valid,
	input  wire logic [0:0]  cfg_index,
	input  wire logic        cfg_data,
	input  wire logic [13:0] prog_addr,
	input  wire logic [15:0] prog_word,
	input  wire logic [15:0] io_low,
	input  wire logic [15:0] io_high,
	output logic             halted,
	output logic [1:0]       status,
	output logic [15:0]      pc_now,
	output logic [15:0]      reg_a,
	output logic [15:0]      reg_b,
	output logic [15:0]      reg_c,
	output logic [15:0]      stack_ptr,
	output logic [1:0]       flags,
	output logic [1:0]       screen_event,
	output logic             pixel_buffer,
	output logic [6:0]       pixel_x,
	output logic [6:0]       pixel_y,
	output logic [5:0]       pixel_color
);
	logic [15:0] a_q, b_q, c_q, pc_q, sp_q, va_q;
	logic cf_q, zf_q, hf_q, bs_q, lo_dir_q, hi_dir_q;
	logic [13:0] paddr_q;
	logic [15:0] pword_q, lo_q, hi_q, ir_q;

	// program memory port
	logic p_we;
	logic [PROG_AW-1:0] p_addr;
	logic [15:0] p_wdata, p_rdata;
	// data memory port
	logic d_we;
	logic [DATA_AW-1:0] d_addr;
	logic [15:0] d_wdata, d_rdata;

	wire logic [7:0] op = ir_q[15:8];
	wire logic [7:0] arg = ir_q[7:0];
	wire logic [15:0] arg16 = {8'd0, arg};
	wire logic [15:0] sp_dec = sp_q - 16'd1;

	acs_ram #(.WIDTH(16), .DEPTH(PROG_WORDS)) u_prog (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
	);
	acs_ram #(.WIDTH(16), .DEPTH(DATA_WORDS)) u_data (
		.clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
	);

	// program memory access: load, fetch, operand read
	always_comb begin
		p_we = cmd.load_word;
		p_wdata = pword_q;
		p_addr = PROG_AW'(pc_q);
		if (cmd.load_word) p_addr = PROG_AW'(paddr_q);
		else if (cmd.fetch) p_addr = PROG_AW'(pc_q);
		else if (cmd.oper_rd) begin
			if (op == 8'd6) p_addr = PROG_AW'(c_q);
			else p_addr = PROG_AW'(arg16);
		end
	end

	// data memory access: operand read before execute, stores in execute
	always_comb begin
		d_we = 1'b0;
		d_wdata = a_q;
		d_addr = DATA_AW'(arg16);
		if (cmd.oper_rd) begin
			priority case (op)
				8'd22, 8'd24, 8'd25, 8'd26: d_addr = DATA_AW'(sp_dec);
				8'd53: d_addr = DATA_AW'(c_q);
				default: d_addr = DATA_AW'(arg16);
			endcase
		end else if (cmd.exec && !hf_q) begin
			priority case (op)
				8'd21, 8'd68: begin d_we = 1'b1; d_addr = DATA_AW'(sp_q); d_wdata = pc_q; end
				8'd23: begin d_we = 1'b1; d_addr = DATA_AW'(sp_q); d_wdata = arg16; end
				8'd27: begin d_we = 1'b1; d_addr = DATA_AW'(sp_q); d_wdata = a_q; end
				8'd28: begin d_we = 1'b1; d_addr = DATA_AW'(sp_q); d_wdata = b_q; end
				8'd29: begin d_we = 1'b1; d_addr = DATA_AW'(sp_q); d_wdata = c_q; end
				8'd63: begin d_we = 1'b1; d_wdata = a_q; end
				8'd64: begin d_we = 1'b1; d_wdata = b_q; end
				8'd65: begin d_we = 1'b1; d_wdata = c_q; end
				8'd79: begin d_we = 1'b1; d_addr = DATA_AW'(c_q); d_wdata = a_q; end
				default: ;
			endcase
		end
	end

	// execute: compute the next architectural state
	logic [16:0] sum;
	logic [15:0] diff, iov, pix_val, pc_inc, na, nb, nc, npc, nsp, nva;
	logic ncf, nzf, nhf, nbs, pix_en;
	logic [1:0] nst, nev;
	logic npb;
	logic [15:0] pword, dword;

	always_comb begin
		sum = {1'b0, a_q} + {1'b0, b_q};
		diff = a_q - b_q;
		iov = (hi_dir_q ? 16'd0 : hi_q) | (lo_dir_q ? 16'd0 : lo_q);
		pword = p_rdata;
		dword = d_rdata;
		pc_inc = pc_q + 16'd1;
		na = a_q; nb = b_q; nc = c_q; nsp = sp_q; nva = va_q;
		ncf = cf_q; nzf = zf_q; nhf = hf_q; nbs = bs_q;
		npc = pc_inc; nst = ST_OK; nev = EV_NONE; npb = 1'b0;
		pix_en = 1'b0; pix_val = a_q;
		unique case (op)
			8'd0: begin nhf = 1'b1; nst = ST_HALT; npc = pc_q; end
			8'd1: na = pword;
			8'd2: na = arg16;
			8'd3: nb = pword;
			8'd4: nb = arg16;
			8'd5: na = iov;
			8'd6: na = pword;
			8'd7: nb = iov;
			8'd8, 8'd9, 8'd10: begin
				ncf = sum[16]; nzf = (sum[15:0] == 16'd0);
				if (op == 8'd8) na = sum[15:0];
				else if (op == 8'd9) nb = sum[15:0];
				else nc = sum[15:0];
			end
			8'd11, 8'd12, 8'd13, 8'd66: begin
				ncf = (a_q < b_q); nzf = (a_q == b_q);
				if (op == 8'd11) na = diff;
				else if (op == 8'd12) nb = diff;
				else if (op == 8'd13) nc = diff;
			end
			8'd14: begin nev = EV_FLIP; npb = bs_q; nbs = !bs_q; end
			8'd15: na = dword;
			8'd16: npc = arg16;
			8'd17: npc = a_q;
			8'd18: npc = b_q;
			8'd19: npc = c_q;
			8'd20: npc = dword;
			8'd21: begin nsp = sp_q + 16'd1; npc = arg16; end
			8'd22: begin nsp = sp_dec; npc = dword + 16'd1; end
			8'd23, 8'd27, 8'd28, 8'd29: nsp = sp_q + 16'd1;
			8'd24: begin nsp = sp_dec; na = dword; end
			8'd25: begin nsp = sp_dec; nb = dword; end
			8'd26: begin nsp = sp_dec; nc = dword; end
			8'd30: nb = dword;
			8'd31: nc = pword;
			8'd32: nc = arg16;
			8'd33: nc = iov;
			8'd34: begin nva = arg16; pix_en = 1'b1; pix_val = a_q; end
			8'd35: begin nva = arg16; pix_en = 1'b1; pix_val = c_q; end
			8'd36: begin pix_en = 1'b1; pix_val = arg16; end
			8'd37: nva = a_q;
			8'd38: nva = b_q;
			8'd39: nva = c_q;
			8'd40: if (zf_q) npc = arg16;
			8'd41: if (zf_q) npc = a_q;
			8'd42: if (zf_q) npc = b_q;
			8'd43: if (zf_q) npc = c_q;
			8'd44, 8'd71: if (zf_q) npc = dword;
			8'd45: if (cf_q) npc = arg16;
			8'd46: if (cf_q) npc = a_q;
			8'd47: if (cf_q) npc = b_q;
			8'd48: if (cf_q) npc = c_q;
			8'd49, 8'd70: if (cf_q) npc = dword;
			8'd53: na = dword;
			8'd54: nb = a_q;
			8'd55: nc = a_q;
			8'd56: na = b_q;
			8'd57: nc = b_q;
			8'd58: na = c_q;
			8'd59: nb = c_q;
			8'd67: nc = dword;
			8'd68: begin nsp = sp_q + 16'd1; npc = pword; end
			8'd69: npc = pword;
			8'd72: begin pix_en = 1'b1; pix_val = c_q; end
			8'd73: npc = pc_inc + arg16;
			8'd74: npc = pc_inc - arg16;
			8'd75: if (cf_q) npc = pc_inc + arg16;
			8'd76: if (cf_q) npc = pc_inc - arg16;
			8'd77: if (zf_q) npc = pc_inc + arg16;
			8'd78: if (zf_q) npc = pc_inc - arg16;
			default: if (op > OP_LAST) nst = ST_BADOP;
		endcase
		// pixel on screen check uses the video address after this item
		if (pix_en && (nva[6:0] <= SCR_MAX_X) && ({nva[15:7]} <= SCR_MAX_Y)) begin
			nev = EV_PIXEL;
			npb = bs_q;
		end else begin
			pix_en = 1'b0;
		end
	end

	// capture item fields and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_dir_q <= 1'b0;
			hi_dir_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IO_LOW_DIR: lo_dir_q <= cfg_data;
				CFG_IO_HIGH_DIR: hi_dir_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			paddr_q <= prog_addr;
			pword_q <= prog_word;
			lo_q <= io_low;
			hi_q <= io_high;
		end
		if (cmd.decode) ir_q <= p_rdata;
	end

	// architectural state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; b_q <= '0; c_q <= '0; pc_q <= '0; sp_q <= '0; va_q <= '0;
			cf_q <= 1'b0; zf_q <= 1'b0; hf_q <= 1'b0; bs_q <= 1'b0;
			status <= ST_OK; screen_event <= EV_NONE; pixel_buffer <= 1'b0;
			pixel_x <= '0; pixel_y <= '0; pixel_color <= '0;
		end else if (cmd.exec) begin
			a_q <= na; b_q <= nb; c_q <= nc; pc_q <= npc; sp_q <= nsp; va_q <= nva;
			cf_q <= ncf; zf_q <= nzf; hf_q <= nhf; bs_q <= nbs;
			status <= nst; screen_event <= nev; pixel_buffer <= npb;
			pixel_x <= pix_en ? nva[6:0] : 7'd0;
			pixel_y <= pix_en ? nva[13:7] : 7'd0;
			pixel_color <= pix_en ? pix_val[5:0] : 6'd0;
		end else if (cmd.halt_out || cmd.load_out) begin
			status <= cmd.halt_out ? ST_HALT : ST_OK;
			screen_event <= EV_NONE; pixel_buffer <= 1'b0;
			pixel_x <= '0; pixel_y <= '0; pixel_color <= '0;
		end
	end

	assign halted = hf_q;
	assign pc_now = pc_q;
	assign reg_a = a_q;
	assign reg_b = b_q;
	assign reg_c = c_q;
	assign stack_ptr = sp_q;
	assign flags = {cf_q, zf_q};
endmodule
`default_nettype wire

FILE: rtl/accumulator_cpu_instruction_step_unit.sv
// Top level of the accumulator CPU step unit: controller plus datapath.
// Depends on acs_pkg, acs_ctrl, acs_datapath, acs_ram.
//
// Usage: an input item (in_valid, in_stall) either loads one program word
// (kind 0) or executes one instruction (kind 1). Each item yields exactly
// one result on the output channel (out_valid, out_stall) carrying status,
// the registers after the item and any screen event.
// Sequencing: a load or an item while halted passes through fetch to its
// result, an executed instruction through fetch, decode, operand read,
// execute and result; the single shared memory port of each RAM and the
// fetch-operand chain set this. One item is in flight at a time: a new
// item is taken only after the result of the last has been delivered.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// sets the IO directions and is always ready; the user is to write it only
// while idle, which the block does not enforce. Reset clears the CPU
// registers and flags; program and data memory hold nothing defined until
// written. While out_stall is high the result holds and no new item is taken.
`default_nettype none
module accumulator_cpu_instruction_step_unit import acs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [13:0] prog_addr,
	input  wire logic [15:0] prog_word,
	input  wire logic [15:0] io_low,
	input  wire logic [15:0] io_high,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic        cfg_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      pc_now,
	output logic [15:0]      reg_a,
	output logic [15:0]      reg_b,
	output logic [15:0]      reg_c,
	output logic [15:0]      stack_ptr,
	output logic [1:0]       flags,
	output logic [1:0]       screen_event,
	output logic             pixel_buffer,
	output logic [6:0]       pixel_x,
	output logic [6:0]       pixel_y,
	output logic [5:0]       pixel_color
);
	ctl_cmd_t cmd;
	logic halted;

	assign cfg_ready = 1'b1;

	acs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_kind(kind), .halted(halted), .out_valid(out_valid),
		.out_stall(out_stall), .cmd(cmd)
	);

	acs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.prog_addr(prog_addr), .prog_word(prog_word), .io_low(io_low), .io_high(io_high),
		.halted(halted), .status(status), .pc_now(pc_now), .reg_a(reg_a),
		.reg_b(reg_b), .reg_c(reg_c), .stack_ptr(stack_ptr), .flags(flags),
		.screen_event(screen_event), .pixel_buffer(pixel_buffer),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color)
	);
endmodule
`default_nettype wire

FILE: verif/accumulator_cpu_instruction_step_unit_tb.sv
// Testbench for accumulator_cpu_instruction_step_unit: self-checking, with its own
// instruction-level predictor, directed and random programs, random idling and stalls.
// Depends on acs_pkg and the RTL of the step unit.
`default_nettype none
module accumulator_cpu_instruction_step_unit_tb;
	import acs_pkg::*;

	typedef enum logic [7:0] {
		OP_HLT = 8'd0, OP_LDA_PM, OP_LDA_IM, OP_LDB_PM, OP_LDB_IM, OP_INA, OP_LDA_PMC, OP_INB,
		OP_ADDA, OP_ADDB, OP_ADDC, OP_SUBA, OP_SUBB, OP_SUBC, OP_FLIP, OP_LDA_DM,
		OP_JMP, OP_JMPA, OP_JMPB, OP_JMPC, OP_JMP_DM, OP_CALL, OP_RET, OP_PUSH_IM,
		OP_POPA, OP_POPB, OP_POPC, OP_PUSHA, OP_PUSHB, OP_PUSHC, OP_LDB_DM, OP_LDC_PM,
		OP_LDC_IM, OP_INC, OP_PIXA, OP_PIXC, OP_PIX_IM, OP_VADA, OP_VADB, OP_VADC,
		OP_JZ, OP_JZA, OP_JZB, OP_JZC, OP_JZ_DM, OP_JC, OP_JCA, OP_JCB,
		OP_JCC, OP_JC_DM, OP_NOP50, OP_NOP51, OP_NOP52, OP_LDA_DMC, OP_MOVBA, OP_MOVCA,
		OP_MOVAB, OP_MOVCB, OP_MOVAC, OP_MOVBC, OP_NOP60, OP_NOP61, OP_NOP62, OP_STA,
		OP_STB, OP_STC, OP_CMP, OP_LDC_DM, OP_CALL_PM, OP_JMP_PM, OP_JC_DM2, OP_JZ_DM2,
		OP_PIXC_V, OP_JR_FWD, OP_JR_BACK, OP_JRC_FWD, OP_JRC_BACK, OP_JRZ_FWD, OP_JRZ_BACK,
		OP_STA_IC
	} cpu_op_t;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] pc, a, b, c, sp;
		logic [1:0]  flags, ev;
		logic        pb;
		logic [6:0]  px, py;
		logic [5:0]  col;
	} step_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, kind = 1'b0;
	logic [13:0] prog_addr = '0;
	logic [15:0] prog_word = '0, io_low = '0, io_high = '0;
	logic cfg_valid = 1'b0, cfg_data = 1'b0;
	logic [0:0] cfg_index = CFG_IO_LOW_DIR;
	logic out_stall = 1'b0;
	logic in_stall, cfg_ready, out_valid, pixel_buffer;
	logic [1:0] status, flags, screen_event;
	logic [15:0] pc_now, reg_a, reg_b, reg_c, stack_ptr;
	logic [6:0] pixel_x, pixel_y;
	logic [5:0] pixel_color;

	// predicted CPU state
	logic [15:0] cpu_a, cpu_b, cpu_c, cpu_pc, cpu_sp, cpu_vaddr;
	logic cpu_zero, cpu_carry, cpu_halted, cpu_bufsel, dir_low, dir_high;
	logic [15:0] prog_mem [PROG_WORDS];
	bit prog_written [PROG_WORDS];
	logic [15:0] data_mem [logic [15:0]];

	step_result_t expected_q[$];
	int errors = 0;
	int send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;

	accumulator_cpu_instruction_step_unit DUT (.*);

	always #4 clk = ~clk;

	// receiver: long hold first, else random stall
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic put_pixel(input logic [15:0] va, input logic [15:0] val,
			inout step_result_t r);
		if (va[6:0] <= SCR_MAX_X && {2'b00, va[15:7]} <= SCR_MAX_Y) begin
			r.ev = EV_PIXEL;
			r.pb = cpu_bufsel;
			r.px = va[6:0];
			r.py = va[13:7];
			r.col = val[5:0];
		end
	endtask

	function automatic logic [15:0] io_value(input logic [15:0] lo, input logic [15:0] hi);
		return (dir_high ? 16'h0 : hi) | (dir_low ? 16'h0 : lo);
	endfunction

	// compute the result of one accepted item and advance the CPU copy
	task automatic predict_step(input logic k, input logic [13:0] addr,
			input logic [15:0] word, input logic [15:0] lo, input logic [15:0] hi);
		step_result_t r;
		logic [15:0] pc, w, arg, tgt;
		logic [16:0] sum;
		logic jmp;
		r = '{default: '0};
		if (!k) begin
			prog_mem[addr] = word;
			prog_written[addr] = 1'b1;
			r.status = ST_OK;
		end else if (cpu_halted) begin
			r.status = ST_HALT;
		end else begin
			pc = cpu_pc;
			w = prog_mem[pc % PROG_WORDS];
			arg = {8'h00, w[7:0]};
			jmp = 1'b0;
			tgt = '0;
			sum = {1'b0, cpu_a} + {1'b0, cpu_b};
			r.status = ST_OK;
			case (w[15:8])
				OP_HLT: begin cpu_halted = 1'b1; r.status = ST_HALT; jmp = 1'b1; tgt = pc; end
				OP_LDA_PM: cpu_a = prog_mem[arg];
				OP_LDA_IM: cpu_a = arg;
				OP_LDB_PM: cpu_b = prog_mem[arg];
				OP_LDB_IM: cpu_b = arg;
				OP_INA: cpu_a = io_value(lo, hi);
				OP_LDA_PMC: cpu_a = prog_mem[cpu_c % PROG_WORDS];
				OP_INB: cpu_b = io_value(lo, hi);
				OP_ADDA, OP_ADDB, OP_ADDC: begin
					cpu_carry = sum[16];
					cpu_zero = (sum[15:0] == 16'h0);
					if (w[15:8] == OP_ADDA) cpu_a = sum[15:0];
					else if (w[15:8] == OP_ADDB) cpu_b = sum[15:0];
					else cpu_c = sum[15:0];
				end
				OP_SUBA, OP_SUBB, OP_SUBC, OP_CMP: begin
					cpu_carry = (cpu_a < cpu_b);
					cpu_zero = (cpu_a == cpu_b);
					if (w[15:8] == OP_SUBA) cpu_a = cpu_a - cpu_b;
					else if (w[15:8] == OP_SUBB) cpu_b = cpu_a - cpu_b;
					else if (w[15:8] == OP_SUBC) cpu_c = cpu_a - cpu_b;
				end
				OP_FLIP: begin r.ev = EV_FLIP; r.pb = cpu_bufsel; cpu_bufsel = ~cpu_bufsel; end
				OP_LDA_DM: cpu_a = data_mem[arg];
				OP_JMP: begin jmp = 1'b1; tgt = arg; end
				OP_JMPA: begin jmp = 1'b1; tgt = cpu_a; end
				OP_JMPB: begin jmp = 1'b1; tgt = cpu_b; end
				OP_JMPC: begin jmp = 1'b1; tgt = cpu_c; end
				OP_JMP_DM: begin jmp = 1'b1; tgt = data_mem[arg]; end
				OP_CALL: begin
					data_mem[cpu_sp] = pc; cpu_sp++; jmp = 1'b1; tgt = arg;
				end
				OP_RET: begin cpu_sp--; pc = data_mem[cpu_sp]; end
				OP_PUSH_IM: begin data_mem[cpu_sp] = arg; cpu_sp++; end
				OP_POPA: begin cpu_sp--; cpu_a = data_mem[cpu_sp]; end
				OP_POPB: begin cpu_sp--; cpu_b = data_mem[cpu_sp]; end
				OP_POPC: begin cpu_sp--; cpu_c = data_mem[cpu_sp]; end
				OP_PUSHA: begin data_mem[cpu_sp] = cpu_a; cpu_sp++; end
				OP_PUSHB: begin data_mem[cpu_sp] = cpu_b; cpu_sp++; end
				OP_PUSHC: begin data_mem[cpu_sp] = cpu_c; cpu_sp++; end
				OP_LDB_DM: cpu_b = data_mem[arg];
				OP_LDC_PM: cpu_c = prog_mem[arg];
				OP_LDC_IM: cpu_c = arg;
				OP_INC: cpu_c = io_value(lo, hi);
				OP_PIXA: begin cpu_vaddr = arg; put_pixel(cpu_vaddr, cpu_a, r); end
				OP_PIXC: begin cpu_vaddr = arg; put_pixel(cpu_vaddr, cpu_c, r); end
				OP_PIX_IM: put_pixel(cpu_vaddr, arg, r);
				OP_VADA: cpu_vaddr = cpu_a;
				OP_VADB: cpu_vaddr = cpu_b;
				OP_VADC: cpu_vaddr = cpu_c;
				OP_JZ: if (cpu_zero) begin jmp = 1'b1; tgt = arg; end
				OP_JZA: if (cpu_zero) begin jmp = 1'b1; tgt = cpu_a; end
				OP_JZB: if (cpu_zero) begin jmp = 1'b1; tgt = cpu_b; end
				OP_JZC: if (cpu_zero) begin jmp = 1'b1; tgt = cpu_c; end
				OP_JZ_DM, OP_JZ_DM2: if (cpu_zero) begin jmp = 1'b1; tgt = data_mem[arg]; end
				OP_JC: if (cpu_carry) begin jmp = 1'b1; tgt = arg; end
				OP_JCA: if (cpu_carry) begin jmp = 1'b1; tgt = cpu_a; end
				OP_JCB: if (cpu_carry) begin jmp = 1'b1; tgt = cpu_b; end
				OP_JCC: if (cpu_carry) begin jmp = 1'b1; tgt = cpu_c; end
				OP_JC_DM, OP_JC_DM2: if (cpu_carry) begin jmp = 1'b1; tgt = data_mem[arg]; end
				OP_NOP50, OP_NOP51, OP_NOP52, OP_NOP60, OP_NOP61, OP_NOP62: ;
				OP_LDA_DMC: cpu_a = data_mem[cpu_c];
				OP_MOVBA: cpu_b = cpu_a;
				OP_MOVCA: cpu_c = cpu_a;
				OP_MOVAB: cpu_a = cpu_b;
				OP_MOVCB: cpu_c = cpu_b;
				OP_MOVAC: cpu_a = cpu_c;
				OP_MOVBC: cpu_b = cpu_c;
				OP_STA: data_mem[arg] = cpu_a;
				OP_STB: data_mem[arg] = cpu_b;
				OP_STC: data_mem[arg] = cpu_c;
				OP_LDC_DM: cpu_c = data_mem[arg];
				OP_CALL_PM: begin
					data_mem[cpu_sp] = pc; cpu_sp++; jmp = 1'b1; tgt = prog_mem[arg];
				end
				OP_JMP_PM: begin jmp = 1'b1; tgt = prog_mem[arg]; end
				OP_PIXC_V: put_pixel(cpu_vaddr, cpu_c, r);
				OP_JR_FWD: pc = pc + arg;
				OP_JR_BACK: pc = pc - arg;
				OP_JRC_FWD: if (cpu_carry) pc = pc + arg;
				OP_JRC_BACK: if (cpu_carry) pc = pc - arg;
				OP_JRZ_FWD: if (cpu_zero) pc = pc + arg;
				OP_JRZ_BACK: if (cpu_zero) pc = pc - arg;
				OP_STA_IC: data_mem[cpu_c] = cpu_a;
				default: r.status = ST_BADOP;
			endcase
			cpu_pc = jmp ? tgt : pc + 16'd1;
		end
		r.pc = cpu_pc; r.a = cpu_a; r.b = cpu_b; r.c = cpu_c; r.sp = cpu_sp;
		r.flags = {cpu_carry, cpu_zero};
		expected_q.push_back(r);
	endtask

	// true when the instruction reads no unwritten memory entry; a halt needs halt_ok
	function automatic bit op_is_safe(input logic [7:0] op, input logic [7:0] arg,
			input bit halt_ok);
		case (op)
			OP_HLT: return halt_ok;
			OP_LDA_PM, OP_LDB_PM, OP_LDC_PM, OP_CALL_PM, OP_JMP_PM: return prog_written[arg];
			OP_LDA_PMC: return prog_written[cpu_c % PROG_WORDS];
			OP_LDA_DM, OP_LDB_DM, OP_LDC_DM, OP_JMP_DM, OP_JZ_DM, OP_JZ_DM2,
			OP_JC_DM, OP_JC_DM2: return data_mem.exists({8'h00, arg});
			OP_RET, OP_POPA, OP_POPB, OP_POPC: return data_mem.exists(cpu_sp - 16'd1);
			OP_LDA_DMC: return data_mem.exists(cpu_c);
			default: return 1'b1;
		endcase
	endfunction

	// offer one item, hold it until taken, drop valid, then maybe idle
	task automatic send_item(input logic k, input logic [13:0] addr, input logic [15:0] word);
		logic [15:0] lo, hi;
		lo = 16'($urandom);
		hi = 16'($urandom);
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		prog_addr <= addr;
		prog_word <= word;
		io_low <= lo;
		io_high <= hi;
		do @(posedge clk); while (in_stall);
		predict_step(k, addr, word, lo, hi);
		@(negedge clk);
		in_valid <= 1'b0;
		if ($urandom_range(99) < send_idle_pct) begin
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// place an instruction at the PC and execute it
	task automatic exec_instr(input logic [7:0] op, input logic [7:0] arg, input bit halt_ok);
		logic [13:0] at;
		at = 14'(cpu_pc % PROG_WORDS);
		if (!op_is_safe(op, arg, halt_ok)) op = OP_LDA_IM;
		send_item(1'b0, at, {op, arg});
		send_item(1'b1, 14'($urandom), 16'($urandom));
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_IO_LOW_DIR) dir_low = val;
		else dir_high = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for every result, then let the block settle
	task automatic drain;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_dirs(input logic lo_dir, input logic hi_dir);
		drain();
		write_reg(CFG_IO_LOW_DIR, lo_dir);
		write_reg(CFG_IO_HIGH_DIR, hi_dir);
	endtask

	// extremes of addresses, PC wrap, flags, pixels, stack and flips
	task automatic test_directed;
		send_item(1'b0, 14'd200, 16'h3FFF);
		send_item(1'b0, 14'd201, 16'hFFFF);
		exec_instr(OP_LDA_PM, 8'd200, 1'b0);
		exec_instr(OP_JMPA, 8'd0, 1'b0);
		exec_instr(8'hFF, 8'hFF, 1'b0);
		exec_instr(OP_LDA_PM, 8'd201, 1'b0);
		exec_instr(OP_JMPA, 8'd0, 1'b0);
		exec_instr(OP_JR_FWD, 8'd1, 1'b0);
		exec_instr(OP_LDB_IM, 8'hFF, 1'b0);
		exec_instr(OP_ADDA, 8'd0, 1'b0);
		exec_instr(OP_SUBA, 8'd0, 1'b0);
		exec_instr(OP_CMP, 8'd0, 1'b0);
		exec_instr(OP_LDA_IM, 8'd63, 1'b0);
		exec_instr(OP_PIXA, 8'd99, 1'b0);
		exec_instr(OP_PIXA, 8'd100, 1'b0);
		exec_instr(OP_PUSHA, 8'd0, 1'b0);
		exec_instr(OP_PUSH_IM, 8'd7, 1'b0);
		exec_instr(OP_POPB, 8'd0, 1'b0);
		exec_instr(OP_CALL, 8'd50, 1'b0);
		exec_instr(OP_RET, 8'd0, 1'b0);
		exec_instr(OP_STA, 8'd5, 1'b0);
		exec_instr(OP_LDC_DM, 8'd5, 1'b0);
		exec_instr(OP_FLIP, 8'd0, 1'b0);
		exec_instr(OP_FLIP, 8'd0, 1'b0);
		exec_instr(OP_LDA_IM, 8'd75, 1'b0);
		exec_instr(OP_VADA, 8'd0, 1'b0);
		exec_instr(OP_PIX_IM, 8'hFF, 1'b0);
	endtask

	// IO reads under every direction setting
	task automatic test_io_dirs;
		for (int d = 0; d < 4; d++) begin
			set_dirs(d[0], d[1]);
			exec_instr(OP_INA, 8'd0, 1'b0);
			exec_instr(OP_INB, 8'd0, 1'b0);
			exec_instr(OP_INC, 8'd0, 1'b0);
		end
	endtask

	// random programs: fresh instructions, reruns of stored code, stray loads
	task automatic test_random(input int n);
		logic [15:0] w;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			w = prog_mem[cpu_pc % PROG_WORDS];
			if (pick < 10) begin
				send_item(1'b0, 14'($urandom), 16'($urandom));
			end else if (pick < 35 && prog_written[cpu_pc % PROG_WORDS]
					&& op_is_safe(w[15:8], w[7:0], 1'b0)) begin
				send_item(1'b1, 14'($urandom), 16'($urandom));
			end else if ($urandom_range(99) < 12) begin
				exec_instr(8'($urandom_range(80, 255)), 8'($urandom), 1'b0);
			end else begin
				exec_instr(8'($urandom_range(1, 79)), 8'($urandom), 1'b0);
			end
		end
	endtask

	// hold the result side while items keep coming, so the input backs up
	task automatic test_backpressure;
		drain();
		hold_cycles = 150;
		test_random(8);
	endtask

	// halt, then execute items report halted while loads still work
	task automatic test_halt;
		exec_instr(OP_HLT, 8'd0, 1'b1);
		send_item(1'b1, 14'($urandom), 16'($urandom));
		send_item(1'b0, 14'd3, 16'h1234);
		send_item(1'b1, 14'($urandom), 16'($urandom));
	endtask

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin : result_check
		step_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result pc_now=%h", $time, pc_now);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if ({status, pc_now, reg_a, reg_b, reg_c, stack_ptr, flags, screen_event,
						pixel_buffer, pixel_x, pixel_y, pixel_color} !==
						{e.status, e.pc, e.a, e.b, e.c, e.sp, e.flags, e.ev,
						e.pb, e.px, e.py, e.col}) begin
					$display("%0t: mismatch expected st=%0d pc=%h a=%h b=%h c=%h sp=%h fl=%0d",
						$time, e.status, e.pc, e.a, e.b, e.c, e.sp, e.flags);
					$display("    ev=%0d pb=%0d x=%0d y=%0d col=%0d", e.ev, e.pb, e.px,
						e.py, e.col);
					$display("%0t: actual   st=%0d pc=%h a=%h b=%h c=%h sp=%h fl=%0d",
						$time, status, pc_now, reg_a, reg_b, reg_c, stack_ptr, flags);
					$display("    ev=%0d pb=%0d x=%0d y=%0d col=%0d", screen_event,
						pixel_buffer, pixel_x, pixel_y, pixel_color);
					errors++;
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		cpu_a = '0; cpu_b = '0; cpu_c = '0; cpu_pc = '0; cpu_sp = '0; cpu_vaddr = '0;
		cpu_zero = 0; cpu_carry = 0; cpu_halted = 0; cpu_bufsel = 0;
		dir_low = 0; dir_high = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		set_dirs(1'b0, 1'b0);
		send_idle_pct = 32;
		recv_stall_pct = 58;
		test_directed();
		test_io_dirs();
		set_dirs(1'b0, 1'b1);
		test_random(150);
		test_backpressure();
		set_dirs(1'b1, 1'b0);
		send_idle_pct = 58;
		recv_stall_pct = 32;
		test_random(150);
		set_dirs(1'b0, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(150);
		test_halt();
		drain();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
rtl/acs_pkg.sv
rtl/acs_ram.sv
rtl/acs_ctrl.sv
rtl/acs_datapath.sv
rtl/accumulator_cpu_instruction_step_unit.sv
verif/accumulator_cpu_instruction_step_unit_tb.sv
